// ----- rtl/sts_pkg.sv -----
package sts_pkg;

  // Field and register widths.
  localparam int RATE_W   = 18;
  localparam int TONE_W   = 17;
  localparam int CHCNT_W  = 4;
  localparam int FMT_W    = 2;
  localparam int CFG_W    = 18;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 15;
  localparam int WORD_W   = 32;
  localparam int CHIDX_W  = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd3;

  // Sample format codes.
  localparam logic [FMT_W-1:0] FMT_U8    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_S16   = 2'd1;
  localparam logic [FMT_W-1:0] FMT_S32   = 2'd2;
  localparam logic [FMT_W-1:0] FMT_FLOAT = 2'd3;

  // Register values after reset.
  localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE   = 18'd48000;
  localparam logic [TONE_W-1:0]  RST_TONE_FREQ     = 17'd1000;
  localparam logic [CHCNT_W-1:0] RST_CHANNEL_COUNT = 4'd2;
  localparam logic [FMT_W-1:0]   RST_SAMPLE_FORMAT = FMT_S16;

  // Result of one compare-and-subtract step.
  typedef struct packed {
    logic              ge;
    logic [RATE_W-1:0] rem;
  } div_res_t;

endpackage

// ----- rtl/sts_divstep.sv -----
// One restoring division step: subtract the divisor when the partial
// remainder reaches it, and report whether the subtraction took place.
module sts_divstep (
  input  logic [sts_pkg::RATE_W:0]   x,
  input  logic [sts_pkg::RATE_W-1:0] d,
  output sts_pkg::div_res_t          res
);

  logic [sts_pkg::RATE_W:0] diff;

  always_comb begin
    diff    = x - {1'b0, d};
    res.ge  = (x >= {1'b0, d});
    res.rem = res.ge ? diff[sts_pkg::RATE_W-1:0] : x[sts_pkg::RATE_W-1:0];
  end

endmodule

// ----- rtl/sts_sine_rom.sv -----
// Quarter-wave sine table with a registered read port. Entry m holds
// round(32767 * sin(2*pi*m / 2^TABLE_ADDR_BITS)) for m up to a quarter turn.
module sts_sine_rom #(
  parameter int TABLE_ADDR_BITS = 12
) (
  input  logic                          clk,
  input  logic [TABLE_ADDR_BITS-2:0]    addr,
  output logic [sts_pkg::AMP_W-1:0]     data
);

  localparam int  QUARTER = 1 << (TABLE_ADDR_BITS - 2);
  localparam int  DEPTH   = QUARTER + 1;
  localparam real PI_VAL  = 3.14159265358979323846;
  localparam real STEP    = 2.0 * PI_VAL / (2.0 ** TABLE_ADDR_BITS);
  localparam real AMP     = 32767.0;

  typedef logic [sts_pkg::AMP_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < DEPTH; i++) begin
      t[i] = sts_pkg::AMP_W'($rtoi(AMP * $sin(STEP * i) + 0.5));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

// ----- rtl/sts_format.sv -----
// Turns one signed sample into the selected output word.
module sts_format (
  input  logic [sts_pkg::FMT_W-1:0]           fmt,
  input  logic signed [sts_pkg::SAMPLE_W-1:0] s,
  output logic [sts_pkg::WORD_W-1:0]          word
);

  localparam logic [16:0] BIAS      = 17'd32767;
  localparam logic [15:0] HALF_SPAN = 16'd32767;
  localparam logic [7:0]  EXP_BIAS  = 8'd112;

  logic [16:0] biased;
  logic [15:0] x;
  logic [23:0] y;
  logic [22:0] z;
  logic [7:0]  hi;
  logic [15:0] lo_sum;
  logic [7:0]  u8;
  logic [14:0] mag;
  logic [3:0]  msb;
  logic [14:0] norm;
  logic [31:0] fbits;

  always_comb begin
    // Unsigned 8 bit: (s + 32767) * 255 / 65534. Halving first leaves a
    // division by 2^15 - 1, which is the high part plus one correction.
    biased = {s[15], s} + BIAS;
    x      = biased[15:0];
    y      = {x, 8'd0} - {8'd0, x};
    z      = y[23:1];
    hi     = z[22:15];
    lo_sum = {1'b0, z[14:0]} + {8'd0, hi};
    u8     = (lo_sum >= HALF_SPAN) ? hi + 8'd1 : hi;

    // Float: magnitude normalized to its leading one.
    mag = s[15] ? 15'(-s) : s[14:0];
    msb = '0;
    for (int i = 0; i < 15; i++) begin
      if (mag[i]) begin
        msb = 4'(i);
      end
    end
    norm  = mag << (4'd14 - msb);
    fbits = (mag == '0) ? '0 : {s[15], 8'(msb) + EXP_BIAS, norm[13:0], 9'd0};

    case (fmt)
      sts_pkg::FMT_U8: begin
        word = {24'd0, u8};
      end
      sts_pkg::FMT_S16: begin
        word = {16'd0, s};
      end
      sts_pkg::FMT_S32: begin
        word = {s, 16'd0};
      end
      sts_pkg::FMT_FLOAT: begin
        word = fbits;
      end
      default: begin
        word = '0;
      end
    endcase
  end

endmodule

// ----- rtl/sine_tone_sample_generator.sv -----
// Channel   Signals                                       Direction  Beat
// tick      tick_valid, tick_stall, restart               in         one frame request
// sample    sample_valid, sample_stall, sample_word,      out        one channel sample
//           channel_index, last_in_frame
// config    cfg_write_en, cfg_index, cfg_data             in         one register write
//
// A frame runs the phase, tone and index divisions (none at a zero sample
// rate) before its first sample beat, then gives one channel beat per cycle
// while the sample side does not stall, and returns to idle before the next
// tick. The divisions share the single compare-and-subtract unit, which runs 18
// steps to reduce the phase, 18 steps to reduce the tone and one step per
// table address bit to form the phase index. tick_stall is high from the
// accepted tick until the frame's last sample beat is taken. Reset is
// synchronous and active high; no clearing pass follows it.
module sine_tone_sample_generator #(
  parameter int TABLE_ADDR_BITS = 12,
  parameter int MAX_CHANNELS    = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Tick channel.
  input  logic                            tick_valid,
  output logic                            tick_stall,
  input  logic                            restart,
  // Sample channel.
  output logic                            sample_valid,
  input  logic                            sample_stall,
  output logic [sts_pkg::WORD_W-1:0]      sample_word,
  output logic [sts_pkg::CHIDX_W-1:0]     channel_index,
  output logic                            last_in_frame,
  // Configuration port.
  input  logic                            cfg_write_en,
  input  logic [sts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sts_pkg::CFG_W-1:0]       cfg_data
);

  localparam int B         = TABLE_ADDR_BITS;
  localparam int ADDR_W    = TABLE_ADDR_BITS - 1;
  localparam int QUARTER   = 1 << (TABLE_ADDR_BITS - 2);
  localparam int STEPS     = (sts_pkg::RATE_W > B) ? sts_pkg::RATE_W : B;
  localparam int CNT_W     = $clog2(STEPS);
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a tick
  localparam logic [2:0] ST_RED  = 3'd1;  // phase residue mod sample rate
  localparam logic [2:0] ST_TMOD = 3'd2;  // tone mod sample rate
  localparam logic [2:0] ST_QUOT = 3'd3;  // phase index, one bit per step
  localparam logic [2:0] ST_WRAP = 3'd4;  // advance residue, table read
  localparam logic [2:0] ST_SINE = 3'd5;  // table data back, format word
  localparam logic [2:0] ST_EMIT = 3'd6;  // one beat per channel

  logic [2:0]                   state;
  logic [sts_pkg::RATE_W-1:0]   sample_rate;
  logic [sts_pkg::TONE_W-1:0]   tone_freq;
  logic [sts_pkg::CHCNT_W-1:0]  channel_count;
  logic [sts_pkg::FMT_W-1:0]    sample_format;
  logic [sts_pkg::RATE_W-1:0]   phase_residue;

  // Divider working registers.
  logic [sts_pkg::RATE_W-1:0]   rem;
  logic [sts_pkg::RATE_W-1:0]   dvd;
  logic [sts_pkg::RATE_W-1:0]   preg;
  logic [sts_pkg::RATE_W-1:0]   treg;
  logic [B-1:0]                 quo;
  logic [CNT_W-1:0]             cnt;
  logic [CH_W-1:0]              chan;

  logic [sts_pkg::RATE_W:0]     div_x;
  sts_pkg::div_res_t            div_res;
  logic                         div_last;
  logic [ADDR_W-1:0]            rom_addr;
  logic [sts_pkg::AMP_W-1:0]    rom_data;
  logic [sts_pkg::SAMPLE_W-1:0] amp16;
  logic signed [sts_pkg::SAMPLE_W-1:0] s_val;
  logic [sts_pkg::WORD_W-1:0]   fmt_word;
  logic [sts_pkg::CHCNT_W-1:0]  n_ch;

  // The shared unit sees the shifted remainder during the divisions and the
  // sum of the two reduced values when the residue is advanced.
  always_comb begin
    if (state == ST_WRAP) begin
      div_x = {1'b0, preg} + {1'b0, treg};
    end else begin
      div_x = {rem, dvd[sts_pkg::RATE_W-1]};
    end
  end

  sts_divstep u_divstep (
    .x   (div_x),
    .d   (sample_rate),
    .res (div_res)
  );

  always_comb begin
    if (state == ST_QUOT) begin
      div_last = (cnt == CNT_W'(B - 1));
    end else begin
      div_last = (cnt == CNT_W'(sts_pkg::RATE_W - 1));
    end
  end

  // Quarter-wave addressing: odd quarters run the table backward, the
  // second half of the turn negates the amplitude.
  always_comb begin
    if (quo[B-2]) begin
      rom_addr = ADDR_W'(QUARTER) - {1'b0, quo[B-3:0]};
    end else begin
      rom_addr = {1'b0, quo[B-3:0]};
    end
  end

  sts_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    amp16 = {1'b0, rom_data};
    s_val = quo[B-1] ? (16'd0 - amp16) : amp16;
  end

  sts_format u_format (
    .fmt  (sample_format),
    .s    (s_val),
    .word (fmt_word)
  );

  // A channel count of zero means one channel; counts above the channel
  // limit are held at the limit.
  always_comb begin
    if (channel_count == '0) begin
      n_ch = 4'd1;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      n_ch = sts_pkg::CHCNT_W'(MAX_CHANNELS);
    end else begin
      n_ch = channel_count;
    end
  end

  assign tick_stall    = (state != ST_IDLE);
  assign channel_index = sts_pkg::CHIDX_W'(chan);
  assign last_in_frame = ((5'(chan) + 5'd1) == 5'(n_ch));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sample_valid  <= 1'b0;
      phase_residue <= '0;
      sample_rate   <= sts_pkg::RST_SAMPLE_RATE;
      tone_freq     <= sts_pkg::RST_TONE_FREQ;
      channel_count <= sts_pkg::RST_CHANNEL_COUNT;
      sample_format <= sts_pkg::RST_SAMPLE_FORMAT;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          sts_pkg::REG_SAMPLE_RATE: begin
            sample_rate <= cfg_data;
          end
          sts_pkg::REG_TONE_FREQ: begin
            tone_freq <= cfg_data[sts_pkg::TONE_W-1:0];
          end
          sts_pkg::REG_CHANNEL_COUNT: begin
            channel_count <= cfg_data[sts_pkg::CHCNT_W-1:0];
          end
          sts_pkg::REG_SAMPLE_FORMAT: begin
            sample_format <= cfg_data[sts_pkg::FMT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (tick_valid) begin
            cnt <= '0;
            rem <= '0;
            if (sample_rate == '0) begin
              // No division: a zero residue and table entry zero give s = 0,
              // and the advance step leaves the residue at zero.
              preg  <= '0;
              treg  <= '0;
              quo   <= '0;
              state <= ST_WRAP;
            end else begin
              dvd   <= restart ? '0 : phase_residue;
              state <= ST_RED;
            end
          end
        end
        ST_RED: begin
          rem <= div_res.rem;
          dvd <= {dvd[sts_pkg::RATE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (div_last) begin
            preg  <= div_res.rem;
            rem   <= '0;
            dvd   <= {1'b0, tone_freq};
            cnt   <= '0;
            state <= ST_TMOD;
          end
        end
        ST_TMOD: begin
          rem <= div_res.rem;
          dvd <= {dvd[sts_pkg::RATE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (div_last) begin
            // The reduced phase is already below the divisor, so the index
            // division starts from it and shifts in zeros.
            treg  <= div_res.rem;
            rem   <= preg;
            dvd   <= '0;
            cnt   <= '0;
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          rem <= div_res.rem;
          quo <= {quo[B-2:0], div_res.ge};
          cnt <= cnt + 1'b1;
          if (div_last) begin
            state <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          phase_residue <= div_res.rem;
          state         <= ST_SINE;
        end
        ST_SINE: begin
          sample_word  <= fmt_word;
          chan         <= '0;
          sample_valid <= 1'b1;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!sample_stall) begin
            if (last_in_frame) begin
              sample_valid <= 1'b0;
              state        <= ST_IDLE;
            end else begin
              chan <= chan + 1'b1;
            end
          end
        end
        default: begin
          sample_valid <= 1'b0;
          state        <= ST_IDLE;
        end
      endcase
    end
  end

  // A new tick is never taken while a sample beat is still on offer.
  a_no_tick_while_emitting: assert property (@(posedge clk) disable iff (rst)
    !tick_stall |-> !sample_valid)
    else $error("tick accepted while samples pending");

  // Taking the final channel's beat ends the frame and reopens the tick side.
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && last_in_frame) |=> (!sample_valid && !tick_stall))
    else $error("frame did not end after its last beat");

  // The channel counter stays inside the frame.
  a_chan_in_frame: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (5'(chan) < 5'(n_ch)))
    else $error("channel index beyond channel count");

  // The advanced residue is always reduced below the sample rate.
  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SINE && sample_rate != '0) |-> (phase_residue < sample_rate))
    else $error("phase residue not reduced");

  // The table address never passes the quarter-turn entry.
  a_rom_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SINE) |-> (rom_addr <= ADDR_W'(QUARTER)))
    else $error("sine table address out of range");

endmodule
